[hw/rtl/cat_pkg.sv]
// Shared types, constants and key builder for the card access table.
`timescale 1ns / 1ps

package cat_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int UID_BYTES         = 7;

    localparam int UID_W       = 56;
    localparam int LEN_W       = 3;
    localparam int KEY_W       = LEN_W + UID_W;
    localparam int WIN_W       = 20;
    localparam int PULSE_W     = 16;
    localparam int ELAPSED_W   = 21;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [WIN_W-1:0]     WINDOW_RESET = 20'd20000;
    localparam logic [PULSE_W-1:0]   PULSE_RESET  = 16'd3000;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_ENROLL_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_PULSE   = 2'd1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CARD,
        OP_ENROLL,
        OP_OPEN
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_AUTH,
        EV_UNKNOWN,
        EV_SAVED,
        EV_EXISTS,
        EV_FULL,
        EV_TIMEOUT,
        EV_ACCEPT
    } ev_t;

    typedef struct packed {
        op_t              opcode;
        logic [UID_W-1:0] card_uid;
        logic [LEN_W-1:0] uid_length;
    } cat_in_t;

    typedef struct packed {
        ev_t                    event_code;
        logic                   relay_on;
        logic                   enroll_active;
        logic [COUNT_OUT_W-1:0] stored_count;
    } cat_out_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_status_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // length in the top bits, bytes beyond the length zeroed
    function automatic logic [KEY_W-1:0] make_key(input logic [UID_W-1:0] uid,
                                                  input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        logic [UID_W-1:0] masked;
        n = len;
        if (int'(n) > UID_BYTES)
            n = LEN_W'(UID_BYTES);
        for (int b = 0; b < UID_W / 8; b++)
            masked[b*8 +: 8] = (b < int'(n)) ? uid[b*8 +: 8] : 8'h00;
        return {n, masked};
    endfunction

endpackage

[hw/rtl/cat_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module cat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/cat_ctrl.sv]
// Sequencing state machine for the card access table.
`timescale 1ns / 1ps

module cat_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cat_pkg::op_t          op,
    input  cat_pkg::dp_status_t   status,
    output logic                  busy,
    output cat_pkg::ctrl_cmd_t    cmd
);

    import cat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= (op == OP_CARD) ? S_SCAN : S_APPLY;
                        busy_reg  <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (status.scan_done)
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.load  = (state_reg == S_IDLE) && start;
        cmd.scan  = (state_reg == S_SCAN);
        cmd.apply = (state_reg == S_APPLY);
    end

    assign busy = busy_reg;

endmodule

[hw/rtl/cat_dp.sv]
// Datapath: ID table, lookup scan, mode/relay counters and result register.
`timescale 1ns / 1ps

module cat_dp #(
    parameter int TABLE_ENTRIES = cat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cat_pkg::cat_in_t      req,
    input  cat_pkg::ctrl_cmd_t    cmd,
    input  cat_pkg::cfg_wr_t      cfg,
    output cat_pkg::dp_status_t   status,
    output logic                  done,
    output cat_pkg::cat_out_t     rsp
);

    import cat_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    // configuration
    logic [WIN_W-1:0]     window_reg;
    logic [PULSE_W-1:0]   pulse_reg;

    // mode and counters
    logic [CW-1:0]        count_reg,   count_next;
    logic                 enroll_reg,  enroll_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [PULSE_W-1:0]   relay_reg,   relay_next;

    // scan
    logic [CW-1:0]        idx_reg,  idx_next;
    logic                 pend_reg, pend_next;
    logic                 hit_reg,  hit_next;
    logic                 issue;

    // latched item and result
    op_t                  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 done_reg;
    cat_out_t             rsp_reg, rsp_next;
    ev_t                  ev;

    logic                 ram_we;
    logic [KEY_W-1:0]     ram_rdata;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    cat_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (key_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // lookup: one read issued per cycle, its entry compared in the next cycle
    assign issue = cmd.scan && !hit_reg && (idx_reg != count_reg);

    always_comb
    begin
        idx_next  = idx_reg;
        pend_next = issue;
        hit_next  = hit_reg | (pend_reg && (ram_rdata == key_reg));
        if (issue)
            idx_next = idx_reg + 1'b1;
        if (cmd.load)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
        end
    end

    assign status.scan_done = !pend_reg && (hit_reg || (idx_reg == count_reg));

    assign elapsed_inc = elapsed_reg + 1'b1;

    always_comb
    begin
        count_next   = count_reg;
        enroll_next  = enroll_reg;
        elapsed_next = elapsed_reg;
        relay_next   = relay_reg;
        ram_we       = 1'b0;
        ev           = EV_NONE;
        if (cmd.apply)
        begin
            unique case (op_reg)
                OP_TICK:
                begin
                    if (relay_reg != '0)
                        relay_next = relay_reg - 1'b1;
                    if (enroll_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > {1'b0, window_reg})
                        begin
                            enroll_next  = 1'b0;
                            elapsed_next = '0;
                            ev           = EV_TIMEOUT;
                        end
                    end
                end
                OP_CARD:
                begin
                    if (enroll_reg)
                    begin
                        if (hit_reg)
                            ev = EV_EXISTS;
                        else if (count_reg == FULL_COUNT)
                            ev = EV_FULL;
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            ev         = EV_SAVED;
                        end
                        enroll_next  = 1'b0;
                        elapsed_next = '0;
                    end
                    else if (hit_reg)
                    begin
                        relay_next = pulse_reg;
                        ev         = EV_AUTH;
                    end
                    else
                        ev = EV_UNKNOWN;
                end
                OP_ENROLL:
                begin
                    enroll_next  = 1'b1;
                    elapsed_next = '0;
                    ev           = EV_ACCEPT;
                end
                OP_OPEN:
                begin
                    relay_next = pulse_reg;
                    ev         = EV_ACCEPT;
                end
                default:
                    ev = EV_NONE;
            endcase
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next.event_code    = ev;
        rsp_next.relay_on      = (relay_next != '0);
        rsp_next.enroll_active = enroll_next;
        rsp_next.stored_count  = count_ext[COUNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RESET;
            pulse_reg   <= PULSE_RESET;
            count_reg   <= '0;
            enroll_reg  <= 1'b0;
            elapsed_reg <= '0;
            relay_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.we && (cfg.index == CFG_ENROLL_WINDOW))
                window_reg <= cfg.data[WIN_W-1:0];
            if (cfg.we && (cfg.index == CFG_RELAY_PULSE))
                pulse_reg <= cfg.data[PULSE_W-1:0];
            count_reg   <= count_next;
            enroll_reg  <= enroll_next;
            elapsed_reg <= elapsed_next;
            relay_reg   <= relay_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            done_reg    <= cmd.apply;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            key_reg <= make_key(req.card_uid, req.uid_length);
        end
        if (cmd.apply)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[hw/rtl/card_access_table_with_enroll.sv]
// Top level of the door access controller with card enrollment.
`timescale 1ns / 1ps

// Door access controller. An item is taken when start is high and busy is
// low; each item gives exactly one result, shown on rsp for one cycle with
// done high. The receiver cannot stall, so rsp must be captured on the done
// cycle. Time ticks, enroll and open-door commands go from accept through
// the apply state to done. A card read walks the ID table through its single
// read port, one entry per cycle with each compare in the cycle after its
// read, and stops early when a match turns up. Configuration writes are taken
// on any cycle (cfg_ready is always high) but should only be made while busy
// is low. The table needs no clearing after reset: only entries below the
// stored count are ever compared.
module card_access_table_with_enroll #(
    parameter int TABLE_ENTRIES = cat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item transfer
    input  logic                              start,
    output logic                              busy,
    input  cat_pkg::cat_in_t                  req,
    // result transfer
    output logic                              done,
    output cat_pkg::cat_out_t                 rsp,
    // configuration transfer
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cat_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import cat_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    cfg_wr_t    cfg;

    // registers are plain flops, so a write always lands
    assign cfg_ready = 1'b1;
    assign cfg.we    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    cat_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (req.opcode),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    cat_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .cfg    (cfg),
        .status (status),
        .done   (done),
        .rsp    (rsp)
    );

    // an accepted item always holds the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accepted");

    // one result per item: strobe is a single cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // the result comes out exactly as the block frees up
    a_done_with_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe not aligned with end of busy");

    // a saved card always closes the enroll window
    a_saved_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.event_code == EV_SAVED)) |-> !rsp.enroll_active)
        else $error("enroll window still open after card saved");

endmodule

[verif/tb.sv]
// Self-checking testbench for the card access table with enrollment.
`timescale 1ns / 1ps

module tb;

    import cat_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    cat_in_t               req       = '0;
    logic                  done;
    cat_out_t              rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    card_access_table_with_enroll u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: own copy of the table, the enroll window, the
    // relay countdown and both registers. Starts at the reset values.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]     id_store [TABLE_ENTRIES_DEF];
    int                   held_count   = 0;
    logic                 enrolling    = 1'b0;
    logic [ELAPSED_W-1:0] enroll_ticks = '0;
    logic [PULSE_W-1:0]   relay_left   = '0;
    logic [WIN_W-1:0]     window_cfg   = WINDOW_RESET;
    logic [PULSE_W-1:0]   pulse_cfg    = PULSE_RESET;

    cat_in_t          pending_items[$];    // items waiting for the driver
    cat_out_t         expected_results[$]; // one per accepted item, oldest first
    logic [KEY_W-1:0] known_keys[$];       // keys offered in enroll windows
    int               items_queued = 0;
    int               err_count    = 0;
    int               gap_left     = 0;    // idle cycles before the next item
    int               quiet_left   = 0;    // items still to send without gaps

    // Key as the table holds it: byte count on top, bytes past the count zeroed.
    // A count above the identifier size is clipped to it.
    function automatic logic [KEY_W-1:0] card_key(logic [UID_W-1:0] uid,
                                                  logic [LEN_W-1:0] len);
        int               nbytes;
        logic [UID_W-1:0] keep_mask;
        nbytes    = (int'(len) > UID_BYTES) ? UID_BYTES : int'(len);
        keep_mask = {UID_W{1'b1}} >> (UID_W - 8 * nbytes);
        return {LEN_W'(nbytes), uid & keep_mask};
    endfunction

    function automatic logic table_holds(logic [KEY_W-1:0] key);
        for (int i = 0; i < held_count && i < TABLE_ENTRIES_DEF; i++)
            if (id_store[i] == key)
                return 1'b1;
        return 1'b0;
    endfunction

    // Advances the predictor by one accepted item and returns its result.
    function automatic cat_out_t predict_door(cat_in_t item);
        cat_out_t         res;
        ev_t              ev;
        logic [KEY_W-1:0] key;
        ev = EV_NONE;
        case (item.opcode)
            OP_TICK:
            begin
                if (relay_left != 0)
                    relay_left = relay_left - 1'b1;
                if (enrolling)
                begin
                    enroll_ticks = enroll_ticks + 1'b1;
                    // window closes once the count passes the register
                    if (enroll_ticks > ELAPSED_W'(window_cfg))
                    begin
                        enrolling    = 1'b0;
                        enroll_ticks = '0;
                        ev           = EV_TIMEOUT;
                    end
                end
            end
            OP_CARD:
            begin
                key = card_key(item.card_uid, item.uid_length);
                if (enrolling)
                begin
                    if (table_holds(key))
                        ev = EV_EXISTS;
                    else if (held_count >= TABLE_ENTRIES_DEF)
                        ev = EV_FULL;
                    else
                    begin
                        id_store[held_count] = key;
                        held_count++;
                        ev = EV_SAVED;
                    end
                    // any card closes the window, whatever the outcome
                    enrolling    = 1'b0;
                    enroll_ticks = '0;
                end
                else if (table_holds(key))
                begin
                    relay_left = pulse_cfg;
                    ev         = EV_AUTH;
                end
                else
                    ev = EV_UNKNOWN;
            end
            OP_ENROLL:
            begin
                // a second enroll restarts the window
                enrolling    = 1'b1;
                enroll_ticks = '0;
                ev           = EV_ACCEPT;
            end
            default:
            begin
                relay_left = pulse_cfg;
                ev         = EV_ACCEPT;
            end
        endcase
        res.event_code    = ev;
        res.relay_on      = (relay_left != 0);
        res.enroll_active = enrolling;
        res.stored_count  = COUNT_OUT_W'(held_count);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: one item per transfer, random gap between items, with
    // occasional stretches of back-to-back items. start stays high across
    // back-to-back transfers.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        int gap;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(predict_door(req));
                if (quiet_left > 0)
                begin
                    gap = 0;
                    quiet_left <= quiet_left - 1;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    gap = 0;
                    quiet_left <= $urandom_range(10, 40);
                end
                else
                    gap = $urandom_range(0, 17);
                if (gap == 0 && pending_items.size() != 0)
                    req <= pending_items.pop_front();
                else
                begin
                    start    <= 1'b0;
                    gap_left <= gap;
                end
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_items.size() != 0)
                begin
                    req   <= pending_items.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done cycle is a result transfer; compare it with the
    // oldest expectation field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        cat_out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with nothing expected: event %0d",
                                          rsp.event_code));
            else
            begin
                want = expected_results.pop_front();
                if (rsp.event_code !== want.event_code)
                    report_mismatch($sformatf("event_code got %0d expected %0d",
                                              rsp.event_code, want.event_code));
                if (rsp.relay_on !== want.relay_on)
                    report_mismatch($sformatf("relay_on got %b expected %b",
                                              rsp.relay_on, want.relay_on));
                if (rsp.enroll_active !== want.enroll_active)
                    report_mismatch($sformatf("enroll_active got %b expected %b",
                                              rsp.enroll_active, want.enroll_active));
                if (rsp.stored_count !== want.stored_count)
                    report_mismatch($sformatf("stored_count got %0d expected %0d",
                                              rsp.stored_count, want.stored_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [UID_W-1:0] rand_uid();
        return UID_W'({$urandom, $urandom});
    endfunction

    task automatic queue_item(op_t op, logic [UID_W-1:0] uid, logic [LEN_W-1:0] len);
        cat_in_t item;
        item.opcode     = op;
        item.card_uid   = uid;
        item.uid_length = len;
        pending_items.push_back(item);
        items_queued++;
    endtask

    // Card read: either a known key with junk above its length (and now and
    // then a wrong length), or a fresh random card.
    task automatic queue_card(bit from_pool, bit remember);
        logic [KEY_W-1:0] k;
        logic [UID_W-1:0] uid;
        logic [LEN_W-1:0] len;
        uid = rand_uid();
        if (from_pool && known_keys.size() != 0)
        begin
            k   = known_keys[$urandom_range(0, known_keys.size() - 1)];
            len = k[KEY_W-1:UID_W];
            for (int b = 0; b < int'(len); b++)
                uid[b*8 +: 8] = k[b*8 +: 8];
            if ($urandom_range(0, 7) == 0)
                len = LEN_W'($urandom_range(0, 7));
        end
        else
            len = LEN_W'($urandom_range(0, 7));
        if (remember)
            known_keys.push_back(card_key(uid, len));
        queue_item(OP_CARD, uid, len);
    endtask

    task automatic queue_ticks(int n);
        for (int i = 0; i < n; i++)
            queue_item(OP_TICK, rand_uid(), LEN_W'($urandom_range(0, 7)));
    endtask

    // Sender holds off until the block is idle with nothing outstanding.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || busy || expected_results.size() != 0);
    endtask

    // Register write over the configuration channel; predictor copy follows
    // at the transfer edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_ENROLL_WINDOW)
            window_cfg = val;
        else if (idx == CFG_RELAY_PULSE)
            pulse_cfg = val[PULSE_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [WIN_W-1:0] win, logic [PULSE_W-1:0] pulse);
        wait_idle();
        write_reg(CFG_ENROLL_WINDOW, win);
        write_reg(CFG_RELAY_PULSE, {4'($urandom), pulse});
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int               target;
        int               pick;
        int               tick_max;
        logic [WIN_W-1:0] win;
        logic [PULSE_W-1:0] pulse;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values: idle tick, empty identifier,
        // open door, repeated enroll, junk above the length, length mismatch,
        // existing card in enroll, relay retrigger.
        queue_item(OP_TICK, '0, '0);
        queue_item(OP_CARD, '0, 3'd0);
        queue_item(OP_OPEN, '0, '0);
        queue_item(OP_ENROLL, '0, '0);
        queue_item(OP_ENROLL, '1, '1);
        queue_item(OP_CARD, '1, 3'd0);
        queue_item(OP_CARD, '0, 3'd0);
        queue_item(OP_ENROLL, '0, '0);
        queue_item(OP_CARD, '1, 3'd7);
        queue_item(OP_CARD, '1, 3'd7);
        queue_item(OP_CARD, '1, 3'd6);
        queue_item(OP_ENROLL, '0, '0);
        queue_item(OP_CARD, '1, 3'd0);
        queue_item(OP_TICK, '0, '0);
        queue_item(OP_OPEN, '0, '0);
        known_keys.push_back(card_key('0, 3'd0));
        known_keys.push_back(card_key('1, 3'd7));

        // zero window times out on the first tick; zero pulse never energises
        set_regs('0, '0);
        queue_item(OP_ENROLL, '0, '0);
        queue_item(OP_TICK, '0, '0);
        queue_item(OP_OPEN, '0, '0);
        queue_item(OP_CARD, '0, 3'd0);

        // largest settings
        set_regs('1, '1);
        queue_item(OP_OPEN, '0, '0);
        queue_item(OP_ENROLL, '0, '0);
        queue_item(OP_TICK, '0, '0);
        queue_card(1'b0, 1'b1);

        // short window: third tick closes it
        set_regs(20'd2, 16'd2);
        queue_item(OP_ENROLL, '0, '0);
        queue_ticks(3);

        // Random phases, each with its own register setting. Mostly
        // enroll-then-card and card reads against known keys, so the table
        // fills and the full case is reached, plus tick runs and noise.
        target = items_queued;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin win = '0; pulse = '0; end
                1: begin win = 20'd1; pulse = 16'd1; end
                2: begin win = 20'd2; pulse = '1; end
                3: begin win = '1; pulse = 16'd2; end
                4: begin win = WIN_W'($urandom_range(0, 12));
                         pulse = PULSE_W'($urandom_range(0, 20)); end
                5: begin win = 20'd3; pulse = PULSE_W'($urandom); end
                6: begin win = WIN_W'($urandom_range(0, 40)); pulse = 16'd3; end
                default: begin win = WINDOW_RESET; pulse = PULSE_RESET; end
            endcase
            set_regs(win, pulse);
            tick_max = (window_cfg < 12) ? int'(window_cfg) + 2 : 6;
            target += 165;
            while (items_queued < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    queue_item(OP_ENROLL, rand_uid(), LEN_W'($urandom));
                    queue_card($urandom_range(0, 9) < 4, 1'b1);
                end
                else if (pick < 50)
                begin
                    queue_item(OP_ENROLL, rand_uid(), LEN_W'($urandom));
                    queue_ticks($urandom_range(0, tick_max));
                    if ($urandom_range(0, 1))
                        queue_card($urandom_range(0, 1), 1'b1);
                end
                else if (pick < 70)
                    queue_card($urandom_range(0, 9) < 6, 1'b0);
                else if (pick < 82)
                    queue_ticks($urandom_range(1, 8));
                else if (pick < 88)
                    queue_item(OP_OPEN, rand_uid(), LEN_W'($urandom));
                else if (pick < 93)
                begin
                    queue_item(OP_ENROLL, '0, '0);
                    queue_item(OP_ENROLL, '0, '0);
                    queue_card($urandom_range(0, 1), 1'b1);
                end
                else
                    queue_item(op_t'($urandom_range(0, 3)), rand_uid(),
                               LEN_W'($urandom_range(0, 7)));
            end
        end

        // all results in, then watch for anything stray
        wait_idle();
        repeat (70) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, well beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/cat_pkg.sv
hw/rtl/cat_ram.sv
hw/rtl/cat_ctrl.sv
hw/rtl/cat_dp.sv
hw/rtl/card_access_table_with_enroll.sv
verif/tb.sv
